[rtl/three_snp_genotype_count_table_top_assert.svh]
// Assertion macros for the three-SNP genotype count table.
// Included by the top level; depends on nothing else.
`ifndef THREE_SNP_GENOTYPE_COUNT_TABLE_TOP_ASSERT_SVH
`define THREE_SNP_GENOTYPE_COUNT_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TSGCT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define TSGCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/tsgct_pkg.sv]
// Package for the three-SNP genotype count table: sizes, saturation cap,
// popcount and saturating add. No dependencies.
package tsgct_pkg;

   localparam int GENOTYPES   = 3;
   localparam int CELLS       = GENOTYPES * GENOTYPES * GENOTYPES;
   localparam int WORD_W      = 32;
   localparam int POP_W       = $clog2(WORD_W + 1);
   localparam int COUNT_W     = 17;
   localparam int IDX_W       = $clog2(CELLS);
   localparam int MAX_SAMPLES = 65536;
   localparam int COUNT_MAX   = (1 << COUNT_W) - 1;

   // counters stop at MAX_SAMPLES, or at the 17-bit ceiling if that is lower
   localparam logic [COUNT_W:0] COUNT_CAP =
      (COUNT_W + 1)'((MAX_SAMPLES < COUNT_MAX) ? MAX_SAMPLES : COUNT_MAX);

   localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(CELLS - 1);

   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [IDX_W-1:0]   idx_type;

   // five-level adder tree
   function automatic logic [POP_W-1:0] popcount32(input word_type w);
      logic [POP_W-1:0] s [WORD_W];
      for (int i = 0; i < WORD_W; i++) begin
         s[i] = POP_W'(w[i]);
      end
      for (int lvl = 0; lvl < POP_W - 1; lvl++) begin
         for (int i = 0; i < (WORD_W >> (lvl + 1)); i++) begin
            s[i] = s[2*i] + s[2*i+1];
         end
      end
      return s[0];
   endfunction

   function automatic count_type sat_add(input count_type acc,
                                         input logic [POP_W-1:0] add);
      logic [COUNT_W:0] sum;
      sum = {1'b0, acc} + (COUNT_W + 1)'(add);
      if (sum > COUNT_CAP) begin
         return COUNT_CAP[COUNT_W-1:0];
      end
      return sum[COUNT_W-1:0];
   endfunction

endpackage

[rtl/three_snp_genotype_count_table_top.sv]
// Three-SNP genotype count table, top level.
// Depends on tsgct_pkg and three_snp_genotype_count_table_top_assert.svh.
// Usage:
//  - req channel: one transaction per 32-sample word, carrying three one-hot
//    genotype planes per SNP, the class word and a last-word flag.
//  - rsp channel: after the word flagged last, 27 transactions, one per cell
//    (g0*9+g1*3+g2) in ascending order, each with the control and case
//    counts; last_cell marks cell 26.
//  - Words are taken one per cycle while no last word is held back in the
//    input register (see below). A word is registered there, and all 27
//    AND/popcount/saturating-add cells update the counters from it together.
//  - On a last word the updated counts are copied to a 27-entry drain buffer
//    and the counters clear, so the next triple accumulates while the table
//    drains. The first cell is presented from the drain buffer, which gives
//    out one cell per rsp take.
//  - A further last word waits in the input register until the cycle after
//    cell 26 of the previous table is taken; ordinary words keep flowing.
//  - When rsp_ready is low the drain buffer holds its head cell unchanged.
//  - Synchronous reset clears the counters, the input valid and the drain.
module three_snp_genotype_count_table_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tsgct_pkg::word_type   req_snp_a_plane0,
   input  tsgct_pkg::word_type   req_snp_a_plane1,
   input  tsgct_pkg::word_type   req_snp_a_plane2,
   input  tsgct_pkg::word_type   req_snp_b_plane0,
   input  tsgct_pkg::word_type   req_snp_b_plane1,
   input  tsgct_pkg::word_type   req_snp_b_plane2,
   input  tsgct_pkg::word_type   req_snp_c_plane0,
   input  tsgct_pkg::word_type   req_snp_c_plane1,
   input  tsgct_pkg::word_type   req_snp_c_plane2,
   input  tsgct_pkg::word_type   req_class_word,
   input  logic                  req_last_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tsgct_pkg::idx_type    rsp_cell_index,
   output tsgct_pkg::count_type  rsp_control_count,
   output tsgct_pkg::count_type  rsp_case_count,
   output logic                  rsp_last_cell
);
   import tsgct_pkg::*;

   `include "three_snp_genotype_count_table_top_assert.svh"

   // input register
   logic     in_valid_ff, in_valid_in;
   logic     in_last_ff;
   word_type a_ff [GENOTYPES];
   word_type b_ff [GENOTYPES];
   word_type c_ff [GENOTYPES];
   word_type cls_ff;

   // accumulating counters
   count_type ctrl_ff [CELLS];
   count_type case_ff [CELLS];
   count_type ctrl_in [CELLS];
   count_type case_in [CELLS];
   count_type ctrl_upd [CELLS];
   count_type case_upd [CELLS];

   // drain buffer, shifted towards entry 0
   count_type snap_ctrl_ff [CELLS];
   count_type snap_case_ff [CELLS];
   logic      drain_busy_ff, drain_busy_in;
   idx_type   drain_idx_ff, drain_idx_in;

   logic stage_fire;
   logic snap_load;
   logic rsp_take;

   // A last word may only leave the input register when the buffer is free.
   assign stage_fire = in_valid_ff && !(in_last_ff && drain_busy_ff);
   assign snap_load  = stage_fire && in_last_ff;
   assign req_ready  = !in_valid_ff || stage_fire;
   assign rsp_take   = drain_busy_ff && rsp_ready;

   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !stage_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && req_ready) begin
         a_ff[0]    <= req_snp_a_plane0;
         a_ff[1]    <= req_snp_a_plane1;
         a_ff[2]    <= req_snp_a_plane2;
         b_ff[0]    <= req_snp_b_plane0;
         b_ff[1]    <= req_snp_b_plane1;
         b_ff[2]    <= req_snp_b_plane2;
         c_ff[0]    <= req_snp_c_plane0;
         c_ff[1]    <= req_snp_c_plane1;
         c_ff[2]    <= req_snp_c_plane2;
         cls_ff     <= req_class_word;
         in_last_ff <= req_last_word;
      end
   end

   // 27 independent cells: AND the planes, split by class, popcount, add.
   always_comb begin
      word_type hit;
      for (int g0 = 0; g0 < GENOTYPES; g0++) begin
         for (int g1 = 0; g1 < GENOTYPES; g1++) begin
            for (int g2 = 0; g2 < GENOTYPES; g2++) begin
               hit = a_ff[g0] & b_ff[g1] & c_ff[g2];
               ctrl_upd[g0*9 + g1*3 + g2] =
                  sat_add(ctrl_ff[g0*9 + g1*3 + g2], popcount32(hit & ~cls_ff));
               case_upd[g0*9 + g1*3 + g2] =
                  sat_add(case_ff[g0*9 + g1*3 + g2], popcount32(hit & cls_ff));
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < CELLS; i++) begin
         if (snap_load) begin
            ctrl_in[i] = '0;
            case_in[i] = '0;
         end else if (stage_fire) begin
            ctrl_in[i] = ctrl_upd[i];
            case_in[i] = case_upd[i];
         end else begin
            ctrl_in[i] = ctrl_ff[i];
            case_in[i] = case_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CELLS; i++) begin
            ctrl_ff[i] <= '0;
            case_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < CELLS; i++) begin
            ctrl_ff[i] <= ctrl_in[i];
            case_ff[i] <= case_in[i];
         end
      end
   end

   // drain control
   always_comb begin
      drain_busy_in = drain_busy_ff;
      drain_idx_in  = drain_idx_ff;
      if (snap_load) begin
         drain_busy_in = 1'b1;
         drain_idx_in  = '0;
      end else if (rsp_take) begin
         drain_idx_in = drain_idx_ff + 1'b1;
         if (drain_idx_ff == LAST_CELL) begin
            drain_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_busy_ff <= 1'b0;
         drain_idx_ff  <= '0;
      end else begin
         drain_busy_ff <= drain_busy_in;
         drain_idx_ff  <= drain_idx_in;
      end
   end

   // buffer payload: load the finished table, or shift one cell per take
   always_ff @(posedge clock) begin
      if (snap_load) begin
         for (int i = 0; i < CELLS; i++) begin
            snap_ctrl_ff[i] <= ctrl_upd[i];
            snap_case_ff[i] <= case_upd[i];
         end
      end else if (rsp_take) begin
         for (int i = 0; i < CELLS - 1; i++) begin
            snap_ctrl_ff[i] <= snap_ctrl_ff[i+1];
            snap_case_ff[i] <= snap_case_ff[i+1];
         end
      end
   end

   assign rsp_valid         = drain_busy_ff;
   assign rsp_cell_index    = drain_idx_ff;
   assign rsp_control_count = snap_ctrl_ff[0];
   assign rsp_case_count    = snap_case_ff[0];
   assign rsp_last_cell     = (drain_idx_ff == LAST_CELL);

   `TSGCT_ASSERT_SAME(a_idx_range, clock, reset, rsp_valid, drain_idx_ff <= LAST_CELL)
   `TSGCT_ASSERT_SAME(a_no_overrun, clock, reset, snap_load, !drain_busy_ff)
   `TSGCT_ASSERT_NEXT(a_drain_start, clock, reset, snap_load,
                      drain_busy_ff && drain_idx_ff == '0)
   `TSGCT_ASSERT_NEXT(a_drain_end, clock, reset, rsp_take && rsp_last_cell, !drain_busy_ff)

endmodule

[tb/sv/tb_three_snp_genotype_count_table_top.sv]
// Self-checking testbench for the three-SNP genotype count table top level.
// Depends on tsgct_pkg and three_snp_genotype_count_table_top; nothing else.
// Words go in on req, the 27-cell tables are predicted and checked on rsp.
module tb_three_snp_genotype_count_table_top;

   // ------------------------------------------------------------------
   // Sizes and run limits
   // ------------------------------------------------------------------
   localparam int GENO      = tsgct_pkg::GENOTYPES;
   localparam int NCELLS    = tsgct_pkg::CELLS;
   localparam int WW        = tsgct_pkg::WORD_W;
   // 17-bit counters cannot hold more than this
   localparam int COUNT_TOP = (1 << tsgct_pkg::COUNT_W) - 1;
   // saturation point: sample ceiling, clipped to the counter width
   localparam int SAT_LIMIT = (tsgct_pkg::MAX_SAMPLES < COUNT_TOP) ?
                              tsgct_pkg::MAX_SAMPLES : COUNT_TOP;
   // words in the long table, 16 + 16 per word into every cell
   localparam int LONG_WORDS = 40;
   localparam int RANDOM_ITEMS = 300;
   // settle time after the last result: input register, update, drain
   localparam int TAIL_CYCLES  = 64;
   localparam int CYCLE_LIMIT  = 1_500_000;

   typedef enum int {IDLE_OFF, IDLE_ON} idle_mode_type;

   // one req transaction; plane[snp][genotype]
   typedef struct packed {
      logic [2:0][2:0][WW-1:0] plane;
      logic [WW-1:0]           class_word;
      logic                    last_word;
   } geno_word_type;

   // one rsp transaction
   typedef struct packed {
      tsgct_pkg::idx_type   index;
      tsgct_pkg::count_type control_cnt;
      tsgct_pkg::count_type case_cnt;
      logic                 last_cell;
   } cell_count_type;

   // ------------------------------------------------------------------
   // Clock, reset and DUT signals
   // ------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_ready;
   tsgct_pkg::word_type  req_snp_a_plane0 = '0;
   tsgct_pkg::word_type  req_snp_a_plane1 = '0;
   tsgct_pkg::word_type  req_snp_a_plane2 = '0;
   tsgct_pkg::word_type  req_snp_b_plane0 = '0;
   tsgct_pkg::word_type  req_snp_b_plane1 = '0;
   tsgct_pkg::word_type  req_snp_b_plane2 = '0;
   tsgct_pkg::word_type  req_snp_c_plane0 = '0;
   tsgct_pkg::word_type  req_snp_c_plane1 = '0;
   tsgct_pkg::word_type  req_snp_c_plane2 = '0;
   tsgct_pkg::word_type  req_class_word   = '0;
   logic                 req_last_word    = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b1;
   tsgct_pkg::idx_type   rsp_cell_index;
   tsgct_pkg::count_type rsp_control_count;
   tsgct_pkg::count_type rsp_case_count;
   logic                 rsp_last_cell;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   three_snp_genotype_count_table_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_snp_a_plane0  (req_snp_a_plane0),
      .req_snp_a_plane1  (req_snp_a_plane1),
      .req_snp_a_plane2  (req_snp_a_plane2),
      .req_snp_b_plane0  (req_snp_b_plane0),
      .req_snp_b_plane1  (req_snp_b_plane1),
      .req_snp_b_plane2  (req_snp_b_plane2),
      .req_snp_c_plane0  (req_snp_c_plane0),
      .req_snp_c_plane1  (req_snp_c_plane1),
      .req_snp_c_plane2  (req_snp_c_plane2),
      .req_class_word    (req_class_word),
      .req_last_word     (req_last_word),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cell_index    (rsp_cell_index),
      .rsp_control_count (rsp_control_count),
      .rsp_case_count    (rsp_case_count),
      .rsp_last_cell     (rsp_last_cell)
   );

   // ------------------------------------------------------------------
   // Shared state
   // ------------------------------------------------------------------
   idle_mode_type req_idle = IDLE_ON;    // sender gaps
   idle_mode_type rsp_idle = IDLE_ON;    // receiver stalls
   int            fail_count  = 0;
   int            cycle_count = 0;

   // running genotype table, mirrors the DUT counters
   tsgct_pkg::count_type control_tally [NCELLS];
   tsgct_pkg::count_type case_tally    [NCELLS];
   // tables still to come out, oldest cell first
   cell_count_type pending_cells [$];

   // ------------------------------------------------------------------
   // Table prediction
   // ------------------------------------------------------------------
   function automatic tsgct_pkg::count_type sat_bump(input tsgct_pkg::count_type acc,
                                                     input int add);
      int sum;
      sum = int'(acc) + add;
      if (sum > SAT_LIMIT) sum = SAT_LIMIT;
      return tsgct_pkg::count_type'(sum);
   endfunction

   // counts one word into the table; a last word closes the table,
   // queues all 27 cells and clears the tallies
   task automatic tally_word(input geno_word_type w);
      logic [WW-1:0]  hit;
      int             cell_no;
      cell_count_type c;
      for (int g0 = 0; g0 < GENO; g0++) begin
         for (int g1 = 0; g1 < GENO; g1++) begin
            for (int g2 = 0; g2 < GENO; g2++) begin
               cell_no = g0 * 9 + g1 * 3 + g2;
               hit     = w.plane[0][g0] & w.plane[1][g1] & w.plane[2][g2];
               control_tally[cell_no] = sat_bump(control_tally[cell_no],
                                                 $countones(hit & ~w.class_word));
               case_tally[cell_no]    = sat_bump(case_tally[cell_no],
                                                 $countones(hit & w.class_word));
            end
         end
      end
      if (w.last_word) begin
         for (int i = 0; i < NCELLS; i++) begin
            c.index       = tsgct_pkg::idx_type'(i);
            c.control_cnt = control_tally[i];
            c.case_cnt    = case_tally[i];
            c.last_cell   = (i == NCELLS - 1);
            pending_cells = {pending_cells, c};
            control_tally[i] = '0;
            case_tally[i]    = '0;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   // mostly back-to-back, some short gaps, a few long ones
   function automatic int pick_gap(input idle_mode_type mode);
      int r;
      if (mode == IDLE_OFF) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // well-formed word: one genotype per SNP for every sample in the mask,
   // padding samples zero in all nine planes
   function automatic geno_word_type make_geno_word(input logic [WW-1:0] used,
                                                    input logic last);
      geno_word_type w;
      w = '0;
      for (int i = 0; i < WW; i++) begin
         if (used[i]) begin
            for (int s = 0; s < 3; s++) begin
               w.plane[s][$urandom_range(0, 2)][i] = 1'b1;
            end
         end
      end
      w.class_word = $urandom;
      w.last_word  = last;
      return w;
   endfunction

   // arbitrary planes, not one-hot
   function automatic geno_word_type make_noise_word(input logic last);
      geno_word_type w;
      for (int s = 0; s < 3; s++) begin
         for (int g = 0; g < 3; g++) begin
            w.plane[s][g] = $urandom;
         end
      end
      w.class_word = $urandom;
      w.last_word  = last;
      return w;
   endfunction

   function automatic geno_word_type make_flat_word(input logic [WW-1:0] planes,
                                                    input logic [WW-1:0] cls,
                                                    input logic last);
      geno_word_type w;
      for (int s = 0; s < 3; s++) begin
         for (int g = 0; g < 3; g++) begin
            w.plane[s][g] = planes;
         end
      end
      w.class_word = cls;
      w.last_word  = last;
      return w;
   endfunction

   // random sample mask: often full, otherwise random padding
   function automatic logic [WW-1:0] pick_mask();
      if ($urandom_range(0, 2) == 0) return '1;
      return $urandom;
   endfunction

   // drives one req transaction and waits for it to be taken; valid stays
   // high on exit so a following zero-gap word needs no second assignment
   task automatic send_word(input geno_word_type w);
      int gap;
      gap = pick_gap(req_idle);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_snp_a_plane0 <= w.plane[0][0];
      req_snp_a_plane1 <= w.plane[0][1];
      req_snp_a_plane2 <= w.plane[0][2];
      req_snp_b_plane0 <= w.plane[1][0];
      req_snp_b_plane1 <= w.plane[1][1];
      req_snp_b_plane2 <= w.plane[1][2];
      req_snp_c_plane0 <= w.plane[2][0];
      req_snp_c_plane1 <= w.plane[2][1];
      req_snp_c_plane2 <= w.plane[2][2];
      req_class_word   <= w.class_word;
      req_last_word    <= w.last_word;
      do begin
         @(posedge clock);
      end while (!req_ready);
      tally_word(w);
   endtask

   // triple of n words, each well-formed or, at noise_pct percent, noise; last flag on the final one
   task automatic send_triple(input int n, input int noise_pct);
      logic [WW-1:0] used;
      used = pick_mask();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < noise_pct)
            send_word(make_noise_word(i == n - 1));
         else
            send_word(make_geno_word(used, i == n - 1));
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // a lone empty last word: table straight out of reset must be all zero
   task automatic test_empty_table();
      send_word(make_flat_word('0, '0, 1'b1));
   endtask

   // field extremes: all planes full with class all control, all case and mixed; then sparse planes, all case
   task automatic test_field_extremes();
      send_word(make_flat_word('1, '0, 1'b1));
      send_word(make_flat_word('1, '1, 1'b1));
      send_word(make_flat_word('1, 32'hA5A5_5A5A, 1'b0));
      send_word(make_flat_word(32'h8000_0001, '1, 1'b1));
   endtask

   // proper one-hot planes, several words accumulating into one table
   task automatic test_one_hot_triple();
      for (int i = 0; i < 5; i++) begin
         send_word(make_geno_word('1, i == 4));
      end
   endtask

   // padding samples must count nowhere
   task automatic test_padding();
      send_word(make_geno_word(32'h0000_FFFF, 1'b0));
      send_word(make_geno_word(32'h0000_0001, 1'b0));
      send_word(make_geno_word(32'h8000_0000, 1'b1));
   endtask

   // planes overlapping or empty: a sample lands in several cells or none
   task automatic test_non_one_hot();
      send_word(make_noise_word(1'b0));
      send_word(make_noise_word(1'b0));
      send_word(make_noise_word(1'b1));
   endtask

   // back-to-back last words: each waits for the previous drain
   task automatic test_back_to_back_tables();
      req_idle = IDLE_OFF;
      rsp_idle = IDLE_ON;
      for (int i = 0; i < 6; i++) begin
         send_word(make_geno_word(pick_mask(), 1'b1));
      end
      req_idle = IDLE_ON;
   endtask

   // long table of full words, half case and half control: large counts
   task automatic test_large_counts();
      req_idle = IDLE_OFF;
      for (int i = 0; i < LONG_WORDS; i++) begin
         send_word(make_flat_word('1, 32'hFFFF_0000, i == LONG_WORDS - 1));
      end
      req_idle = IDLE_ON;
   endtask

   // mostly well-formed triples with random content, some noise triples
   task automatic test_random_triples();
      int sent;
      int n;
      int r;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         req_idle = ($urandom_range(0, 3) == 0) ? IDLE_OFF : IDLE_ON;
         rsp_idle = ($urandom_range(0, 3) == 0) ? IDLE_OFF : IDLE_ON;
         r = $urandom_range(0, 99);
         if (r < 70)      n = $urandom_range(1, 8);
         else if (r < 90) n = $urandom_range(9, 40);
         else             n = 1;
         if ($urandom_range(0, 99) < 85)
            send_triple(n, 10);
         else
            send_triple(n, 100);
         sent += n;
      end
      req_idle = IDLE_ON;
      rsp_idle = IDLE_ON;
   endtask

   // ------------------------------------------------------------------
   // Receiver back-pressure: ready held for random stretches
   // ------------------------------------------------------------------
   initial begin : rsp_ready_gen
      int   hold;
      logic level;
      forever begin
         if (rsp_idle == IDLE_OFF) begin
            level = 1'b1;
            hold  = 1;
         end else begin
            level = ($urandom_range(0, 2) != 0);
            hold  = level ? $urandom_range(1, 12) : pick_gap(IDLE_ON) + 1;
         end
         rsp_ready <= level;
         repeat (hold) @(posedge clock);
      end
   end

   // ------------------------------------------------------------------
   // Result checker: each rsp transaction against the oldest expected cell
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_cells
      cell_count_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_cells.size() == 0) begin
            $error("unexpected rsp transaction: cell_index %0d", rsp_cell_index);
            fail_count++;
         end else begin
            want = pending_cells.pop_front();
            if (rsp_cell_index !== want.index) begin
               $error("cell_index: expected %0d, actual %0d", want.index, rsp_cell_index);
               fail_count++;
            end
            if (rsp_control_count !== want.control_cnt) begin
               $error("control_count: expected %0d, actual %0d",
                      want.control_cnt, rsp_control_count);
               fail_count++;
            end
            if (rsp_case_count !== want.case_cnt) begin
               $error("case_count: expected %0d, actual %0d", want.case_cnt, rsp_case_count);
               fail_count++;
            end
            if (rsp_last_cell !== want.last_cell) begin
               $error("last_cell: expected %0d, actual %0d", want.last_cell, rsp_last_cell);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sequence of tests
   // ------------------------------------------------------------------
   initial begin
      for (int i = 0; i < NCELLS; i++) begin
         control_tally[i] = '0;
         case_tally[i]    = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_field_extremes();
      test_one_hot_triple();
      test_padding();
      test_non_one_hot();
      test_back_to_back_tables();
      test_large_counts();
      test_random_triples();

      // all words taken: drop valid, then let the tables drain
      req_valid <= 1'b0;
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_cells.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/tsgct_pkg.sv
rtl/three_snp_genotype_count_table_top.sv
tb/sv/tb_three_snp_genotype_count_table_top.sv
